/* src/pci_pkg.sv */
package pci_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ATTR_W     = 32;
  localparam int DEPTH_W    = 31;
  localparam int WEIGHT_W   = 17;
  localparam int LANES      = 3;

  // ratio = weight * 2^RATIO_FRAC / depth, saturated to RATIO_W bits
  localparam int RATIO_FRAC = 2 * FRAC_BITS;
  localparam int RATIO_W    = 46;
  localparam int RSUM_W     = 48;
  localparam int WSUM_W     = 64;
  localparam int TERM_SHIFT = FRAC_BITS;

  // serial divider: dividend shift register and quotient widths
  localparam int NUM_W      = WSUM_W + TERM_SHIFT;
  localparam int QUO_W      = WEIGHT_W + RATIO_FRAC;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] RDIV_STEPS = CNT_W'(QUO_W);
  localparam logic [CNT_W-1:0] FDIV_STEPS = CNT_W'(NUM_W);

  // serial multiplier widths
  localparam int PROD_W     = ATTR_W + RATIO_W;
  localparam int TERM_W     = PROD_W - TERM_SHIFT;
  localparam int MCNT_W     = $clog2(ATTR_W);

  localparam logic [ATTR_W-1:0] SAT_MAX = {1'b0, {(ATTR_W-1){1'b1}}};
  localparam logic [ATTR_W-1:0] SAT_MIN = {1'b1, {(ATTR_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ATTR_W-1:0] attr_x;
    logic signed [ATTR_W-1:0] attr_y;
    logic signed [ATTR_W-1:0] attr_z;
    logic [DEPTH_W-1:0]       depth;
    logic [WEIGHT_W-1:0]      weight;
  } pci_in_t;

  typedef struct packed {
    logic signed [ATTR_W-1:0] out_x;
    logic signed [ATTR_W-1:0] out_y;
    logic signed [ATTR_W-1:0] out_z;
    logic                     error;
  } pci_out_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [RSUM_W-1:0] den;
    logic [CNT_W-1:0]  steps;
  } pci_div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDIV,
    ST_MUL,
    ST_NEXT,
    ST_FDIV,
    ST_DONE
  } pci_state_t;

endpackage

/* src/pci_sdiv.sv */
module pci_sdiv import pci_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  pci_div_req_t       req,
  output logic               done,
  output logic [QUO_W-1:0]   quo,
  output logic               ovf
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [RSUM_W-1:0] den_r, den_nxt;
  logic [RSUM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic              ovf_r, ovf_nxt;

  logic [RSUM_W:0]   rem_sh;
  logic [RSUM_W+1:0] diff;
  logic              ge;

  always_comb begin
    // restoring step: one quotient bit per cycle
    rem_sh = {rem_r, num_r[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = !diff[RSUM_W+1];

    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = req.steps - CNT_W'(1);
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      rem_nxt = ge ? diff[RSUM_W-1:0] : rem_sh[RSUM_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      // sticky flag for quotient bits beyond the register
      ovf_nxt = ovf_r | quo_r[QUO_W-1];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign ovf  = ovf_r;

endmodule

/* src/pci_smul.sv */
module pci_smul import pci_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [ATTR_W-1:0]  mag,
  input  logic [RATIO_W-1:0] ratio,
  output logic               done,
  output logic [TERM_W-1:0]  term
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [MCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RATIO_W-1:0] mcand_r, mcand_nxt;
  logic [ATTR_W-1:0]  mplier_r, mplier_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;

  logic [RATIO_W:0]   upper;

  always_comb begin
    // shift-add, multiplier bits lsb first
    upper = {1'b0, prod_r[PROD_W-1:ATTR_W]}
          + (mplier_r[0] ? {1'b0, mcand_r} : '0);

    busy_nxt   = busy_r;
    done_nxt   = done_r;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    prod_nxt   = prod_r;
    if (start) begin
      busy_nxt   = 1'b1;
      done_nxt   = 1'b0;
      cnt_nxt    = MCNT_W'(ATTR_W - 1);
      mcand_nxt  = ratio;
      mplier_nxt = mag;
      prod_nxt   = '0;
    end else if (busy_r) begin
      prod_nxt   = {upper, prod_r[ATTR_W-1:1]};
      mplier_nxt = {1'b0, mplier_r[ATTR_W-1:1]};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - MCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r   <= prod_nxt;
  end

  assign done = done_r;
  assign term = prod_r[PROD_W-1:TERM_SHIFT];

endmodule

/* src/perspective_correct_interpolator_unit.sv */
// Perspective-correct interpolator: takes a triangle's three vertices as three requests
// (attribute x/y/z Q16.16, depth Q15.16, weight Q1.16) and returns one result after the
// third, the weight/depth-weighted attribute mean in Q16.16, truncated and saturated, with
// error set and zero values when a depth or the ratio sum is zero. Requests are taken one
// at a time. A vertex with nonzero depth passes through the bit-serial weight/depth
// divider, then the three bit-serial multipliers that run side by side; a zero-depth
// vertex skips both. Unless an error is set, the third vertex then runs the 80-step final
// divides, the three components in parallel. A finished result sits in an output
// register, so the next triangle's first vertex is accepted while it waits to be taken.
module perspective_correct_interpolator_unit import pci_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pci_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pci_out_t out_data
);

  pci_state_t        state_r, state_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              zseen_r, zseen_nxt;
  logic              err_r, err_nxt;
  logic [RSUM_W-1:0] rsum_r, rsum_nxt;
  logic [WSUM_W-1:0] wsum_r [LANES];
  logic [WSUM_W-1:0] wsum_nxt [LANES];
  logic [ATTR_W-1:0] attr_r [LANES];
  logic [ATTR_W-1:0] attr_nxt [LANES];
  logic              out_valid_r, out_valid_nxt;
  pci_out_t          out_data_r, out_data_nxt;

  pci_div_req_t      div_req [LANES];
  logic              div_done [LANES];
  logic [QUO_W-1:0]  div_quo [LANES];
  logic              div_ovf [LANES];
  logic              mul_start;
  logic [ATTR_W-1:0] mul_mag [LANES];
  logic              mul_done [LANES];
  logic [TERM_W-1:0] mul_term [LANES];
  logic [RATIO_W-1:0] ratio_c;
  logic [ATTR_W-1:0] fin_val [LANES];
  logic [WSUM_W-1:0] fin_mag;

  // quotient to saturated signed Q16.16
  function automatic logic [ATTR_W-1:0] fin_value(logic neg, logic ovf,
                                                  logic [QUO_W-1:0] q);
    logic              big;
    logic [ATTR_W-1:0] lo;
    big = ovf || (|q[QUO_W-1:ATTR_W]);
    lo  = q[ATTR_W-1:0];
    if (neg) begin
      if (big || lo > SAT_MIN) return SAT_MIN;
      return -lo;
    end
    if (big || lo[ATTR_W-1]) return SAT_MAX;
    return lo;
  endfunction

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pci_sdiv u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (div_req[g]),
      .done  (div_done[g]),
      .quo   (div_quo[g]),
      .ovf   (div_ovf[g])
    );
    pci_smul u_mul (
      .clk   (clk),
      .rst_n (rst_n),
      .start (mul_start),
      .mag   (mul_mag[g]),
      .ratio (ratio_c),
      .done  (mul_done[g]),
      .term  (mul_term[g])
    );
  end

  always_comb begin
    fin_mag = '0;
    ratio_c = (div_ovf[0] || (|div_quo[0][QUO_W-1:RATIO_W])) ? '1
                                                              : div_quo[0][RATIO_W-1:0];
    for (int k = 0; k < LANES; k++) begin
      fin_mag = wsum_r[k][WSUM_W-1] ? -wsum_r[k] : wsum_r[k];
      div_req[k].start = 1'b0;
      div_req[k].num   = {fin_mag, {TERM_SHIFT{1'b0}}};
      div_req[k].den   = rsum_r;
      div_req[k].steps = FDIV_STEPS;
      mul_mag[k] = attr_r[k][ATTR_W-1] ? -attr_r[k] : attr_r[k];
      fin_val[k] = fin_value(wsum_r[k][WSUM_W-1], div_ovf[k], div_quo[k]);
      wsum_nxt[k] = wsum_r[k];
      attr_nxt[k] = attr_r[k];
    end
    if (state_r == ST_IDLE) begin
      // lane 0 divider doubles as the weight/depth unit
      div_req[0].num   = {in_data.weight, {(NUM_W-WEIGHT_W){1'b0}}};
      div_req[0].den   = RSUM_W'(in_data.depth);
      div_req[0].steps = RDIV_STEPS;
    end

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    zseen_nxt     = zseen_r;
    err_nxt       = err_r;
    rsum_nxt      = rsum_r;
    mul_start     = 1'b0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          attr_nxt[0] = in_data.attr_x;
          attr_nxt[1] = in_data.attr_y;
          attr_nxt[2] = in_data.attr_z;
          if (in_data.depth == '0) begin
            zseen_nxt = 1'b1;
            state_nxt = ST_NEXT;
          end else begin
            div_req[0].start = 1'b1;
            state_nxt = ST_RDIV;
          end
        end
      end
      ST_RDIV: begin
        if (div_done[0]) begin
          rsum_nxt  = rsum_r + RSUM_W'(ratio_c);
          mul_start = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done[0] && mul_done[1] && mul_done[2]) begin
          for (int k = 0; k < LANES; k++) begin
            wsum_nxt[k] = attr_r[k][ATTR_W-1] ? wsum_r[k] - WSUM_W'(mul_term[k])
                                              : wsum_r[k] + WSUM_W'(mul_term[k]);
          end
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (cnt_r != 2'd2) begin
          cnt_nxt   = cnt_r + 2'd1;
          state_nxt = ST_IDLE;
        end else if (zseen_r || rsum_r == '0) begin
          err_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          err_nxt = 1'b0;
          for (int k = 0; k < LANES; k++) div_req[k].start = 1'b1;
          state_nxt = ST_FDIV;
        end
      end
      ST_FDIV: begin
        if (div_done[0] && div_done[1] && div_done[2]) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_data_nxt.out_x = err_r ? '0 : fin_val[0];
          out_data_nxt.out_y = err_r ? '0 : fin_val[1];
          out_data_nxt.out_z = err_r ? '0 : fin_val[2];
          out_data_nxt.error = err_r;
          cnt_nxt   = '0;
          zseen_nxt = 1'b0;
          rsum_nxt  = '0;
          for (int k = 0; k < LANES; k++) wsum_nxt[k] = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      zseen_r     <= 1'b0;
      rsum_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < LANES; k++) wsum_r[k] <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      zseen_r     <= zseen_nxt;
      rsum_r      <= rsum_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < LANES; k++) wsum_r[k] <= wsum_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
    for (int k = 0; k < LANES; k++) attr_r[k] <= attr_nxt[k];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("vertex count out of range");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside done state");

  a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && state_nxt == ST_IDLE) |=>
      (rsum_r == '0 && cnt_r == 2'd0 && !zseen_r))
    else $error("sums not cleared after result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error) |->
      (out_data_r.out_x == '0 && out_data_r.out_y == '0 && out_data_r.out_z == '0))
    else $error("error result carries nonzero values");
`endif

endmodule
